[design/lss_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants for the LIFO stack with search.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int CMD_W      = 2;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic advance;
    logic finish;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic empty;
    logic scan_hit;
    logic scan_last;
  } dp_stat_t;

endpackage : lss_pkg
`default_nettype wire

[design/lss_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lss_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule : lss_ram
`default_nettype wire

[design/lss_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lss_ctrl
// Controller: sequences one transaction at a time and owns the output valid.
// ----------------------------------------------------------------------------
module lss_ctrl
  import lss_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      ctl
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   done;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    ctl         = '0;
    done        = (stat.cmd != CMD_SEARCH) || stat.empty || stat.scan_hit || stat.scan_last;
    out_free    = !out_valid_r || out_tready;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (done && out_free) begin
          ctl.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else if (!done) begin
          ctl.advance = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = ctl.finish ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  assign out_tvalid = out_valid_r;

endmodule : lss_ctrl
`default_nettype wire

[design/lss_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lss_dp
// Datapath: fill count, entry RAM, scan index, and result registers.
// ----------------------------------------------------------------------------
module lss_dp
  import lss_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ctl_cmd_t           ctl,
  input  wire logic [CMD_W-1:0]   in_cmd,
  input  wire logic [VALUE_W-1:0] in_value,
  output dp_stat_t                stat,
  output logic [VALUE_W-1:0]      res_read_value,
  output logic                    res_found,
  output status_t                 res_status,
  output logic [COUNT_W-1:0]      res_count,
  output logic                    res_is_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [FW-1:0]         fill_r, fill_nxt;
  logic [FW-1:0]         fill_m1;
  cmd_t                  cmd_r;
  logic [DATA_WIDTH-1:0] word_r;
  logic [AW-1:0]         idx_r;
  logic [AW-1:0]         top_addr;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] rdata;
  logic                  empty;
  logic                  full;
  logic                  we;

  logic [VALUE_W-1:0]    read_value_r;
  logic                  found_r;
  status_t               status_r;
  logic [COUNT_W-1:0]    count_r;
  logic                  is_empty_r;
  status_t               status_nxt;

  assign fill_m1  = fill_r - FW'(1);
  assign top_addr = fill_m1[AW-1:0];
  assign empty    = (fill_r == '0);
  assign full     = (fill_r == FW'(DEPTH));
  assign we       = ctl.finish && (cmd_r == CMD_PUSH) && !full;

  always_comb begin
    if (ctl.load) begin
      raddr = (cmd_t'(in_cmd) == CMD_SEARCH) ? '0 : top_addr;
    end else if (cmd_r == CMD_SEARCH) begin
      raddr = ctl.advance ? (idx_r + AW'(1)) : idx_r;
    end else begin
      raddr = top_addr;
    end
  end

  lss_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (fill_r[AW-1:0]),
    .wdata (word_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    stat.cmd       = cmd_r;
    stat.empty     = empty;
    stat.scan_hit  = (rdata == word_r);
    stat.scan_last = (FW'(idx_r) == fill_m1);
  end

  always_comb begin
    fill_nxt   = fill_r;
    status_nxt = ST_OK;
    case (cmd_r)
      CMD_PUSH: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          fill_nxt = fill_r + FW'(1);
        end
      end
      CMD_POP: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          fill_nxt = fill_m1;
        end
      end
      CMD_PEEK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (ctl.finish) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= cmd_t'(in_cmd);
      word_r <= DATA_WIDTH'(in_value);
      idx_r  <= '0;
    end else if (ctl.advance) begin
      idx_r  <= idx_r + AW'(1);
    end
    if (ctl.finish) begin
      read_value_r <= ((cmd_r == CMD_PEEK) && !empty) ? VALUE_W'(rdata) : '0;
      found_r      <= (cmd_r == CMD_SEARCH) && !empty && (rdata == word_r);
      status_r     <= status_nxt;
      count_r      <= COUNT_W'(fill_nxt);
      is_empty_r   <= (fill_nxt == '0);
    end
  end

  assign res_read_value = read_value_r;
  assign res_found      = found_r;
  assign res_status     = status_r;
  assign res_count      = count_r;
  assign res_is_empty   = is_empty_r;

endmodule : lss_dp
`default_nettype wire

[design/lifo_stack_with_search.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// LIFO stack of DEPTH words with push, pop, peek and a contains search.
//
// Input stream: in_tuser carries the command (push, pop, peek, search),
// in_tdata the word to push or to search for. Every transaction gives
// exactly one result transaction on the output stream: the peeked word,
// the found flag, entry count and empty flag in out_tdata, status in
// out_tuser.
// Push, pop and peek pass from the idle state through the execute state,
// and a new input is accepted only in the idle state.
// A search walks the held entries through the single RAM read port, one
// entry per cycle from the bottom entry up, and stops at the first match
// or at the last held entry. One transaction is in work at a time.
// The result register lets the next input be accepted while a result
// waits; a finished result stalls in the controller until the register
// frees. Reset clears the entry count; the stack is empty after reset.
// ----------------------------------------------------------------------------
module lifo_stack_with_search
  import lss_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [VALUE_W-1:0]    in_tdata,   // value[31:0]
  input  wire logic [CMD_W-1:0]      in_tuser,   // cmd[1:0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // read_value, found, count, is_empty, pad
  output logic [STATUS_W-1:0]        out_tuser   // status[1:0]
);

  ctl_cmd_t           ctl;
  dp_stat_t           stat;
  logic [VALUE_W-1:0] res_read_value;
  logic               res_found;
  status_t            res_status;
  logic [COUNT_W-1:0] res_count;
  logic               res_is_empty;

  lss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .ctl        (ctl)
  );

  lss_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .in_cmd         (in_tuser),
    .in_value       (in_tdata),
    .stat           (stat),
    .res_read_value (res_read_value),
    .res_found      (res_found),
    .res_status     (res_status),
    .res_count      (res_count),
    .res_is_empty   (res_is_empty)
  );

  assign out_tdata = {1'b0, res_is_empty, res_count, res_found, res_read_value};
  assign out_tuser = res_status;

endmodule : lifo_stack_with_search
`default_nettype wire
